// ----- rtl/utf8_stream_decoder_unit_defines.svh -----
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Used by files that include this header; expects aclk and aresetn in scope.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define UTF8SD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("utf8 decoder assertion failed");
// next-cycle implication, checked out of reset
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("utf8 decoder assertion failed");
`else
`define UTF8SD_ASSERT_IMPL(lbl, ante, cons)
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/utf8sd_pkg.sv -----
// Package for the UTF-8 stream decoder: types, constants and byte-class helpers.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package utf8sd_pkg;

    localparam int BUF_DEPTH   = 4;
    localparam int CP_W        = 21;
    localparam int TDATA_OUT_W = 24;
    localparam int TDATA_IN_W  = 8;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_CODE   = 8'h80;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

    typedef logic [BUF_DEPTH-1:0][7:0] bytes4_t;

    // decode of the buffer front
    typedef struct packed {
        logic            work;       // a result is due from the buffer
        logic            last;       // this result ends the run of the current byte
        logic [CP_W-1:0] value;      // code point or raw lead byte
        logic [2:0]      rem_count;  // bytes left after this result is taken
    } dec_t;

    // one result item
    typedef struct packed {
        logic [CP_W-1:0] value;
        logic            string_done;
        logic            run_done;
    } res_t;

    // total length announced by a lead byte, LEN_NONE if not a multi-byte lead
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_NONE;
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            len = LEN_TWO;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            len = LEN_THREE;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_CODE;
    endfunction

    // all bytes after the lead that are both present and needed are continuations
    function automatic logic prefix_ok(input bytes4_t b, input logic [2:0] n,
                                       input logic [2:0] len);
        logic ok;
        ok = 1'b1;
        for (int k = 1; k < BUF_DEPTH; k++) begin
            if ((3'(k) < len) && (3'(k) < n) && !is_cont(b[k])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // the buffer holds a valid but incomplete sequence
    function automatic logic partial_seq(input bytes4_t b, input logic [2:0] n);
        logic [2:0] len;
        len = seq_len(b[0]);
        return (n != 3'd0) && (len != LEN_NONE) && (n < len) && prefix_ok(b, n, len);
    endfunction

endpackage

// ----- rtl/utf8sd_decode.sv -----
// Front decoder: finds the next result in the byte buffer and the bytes left after it.
// Depends on utf8sd_pkg.
`timescale 1ns / 1ps

module utf8sd_decode (
    input  utf8sd_pkg::bytes4_t buf_bytes,
    input  logic [2:0]          buf_count,
    input  logic                final_flag,
    output utf8sd_pkg::dec_t    dec,
    output utf8sd_pkg::bytes4_t rem_bytes
);

    logic [2:0]                  len;
    logic                        ok;
    logic                        complete;
    logic [utf8sd_pkg::CP_W-1:0] cp;
    logic                        in_range;
    logic [2:0]                  consume;
    logic [2:0]                  idx;
    logic [2:0]                  rem_n;
    logic                        front_work;
    logic [utf8sd_pkg::CP_W-1:0] front_value;

    // assemble the code point from lead and continuation payload bits
    always_comb begin
        case (len)
            utf8sd_pkg::LEN_TWO: begin
                cp = {10'd0, buf_bytes[0][4:0], buf_bytes[1][5:0]};
            end
            utf8sd_pkg::LEN_THREE: begin
                cp = {5'd0, buf_bytes[0][3:0], buf_bytes[1][5:0], buf_bytes[2][5:0]};
            end
            utf8sd_pkg::LEN_FOUR: begin
                cp = {buf_bytes[0][2:0], buf_bytes[1][5:0], buf_bytes[2][5:0],
                      buf_bytes[3][5:0]};
            end
            default: begin
                cp = '0;
            end
        endcase
    end

    // classify the front of the buffer
    always_comb begin
        len      = utf8sd_pkg::seq_len(buf_bytes[0]);
        ok       = utf8sd_pkg::prefix_ok(buf_bytes, buf_count, len);
        complete = buf_count >= len;
        in_range = (cp <= utf8sd_pkg::CP_MAX) &&
                   !((cp >= utf8sd_pkg::SURR_LO) && (cp <= utf8sd_pkg::SURR_HI));

        front_work  = 1'b1;
        front_value = {13'd0, buf_bytes[0]};
        consume     = 3'd1;
        if (buf_count == 3'd0) begin
            front_work = 1'b0;
            consume    = 3'd0;
        end else if ((len == utf8sd_pkg::LEN_NONE) || !ok) begin
            // plain byte, invalid lead or broken sequence: raw lead
            consume = 3'd1;
        end else if (!complete) begin
            // open sequence: raw lead at end of string, else keep waiting
            if (!final_flag) begin
                front_work = 1'b0;
                consume    = 3'd0;
            end
        end else if (in_range) begin
            front_value = cp;
            consume     = len;
        end
    end

    // shift out the consumed bytes
    always_comb begin
        rem_n = buf_count - consume;
        for (int k = 0; k < utf8sd_pkg::BUF_DEPTH; k++) begin
            idx = 3'(k) + consume;
            rem_bytes[k] = (idx < 3'(utf8sd_pkg::BUF_DEPTH)) ? buf_bytes[idx[1:0]] : 8'd0;
        end
        dec.work      = front_work;
        dec.value     = front_value;
        dec.rem_count = rem_n;
        dec.last      = (rem_n == 3'd0) ||
                        (!final_flag && utf8sd_pkg::partial_seq(rem_bytes, rem_n));
    end

endmodule

// ----- rtl/utf8sd_out_reg.sv -----
// Result register with a skid stage in front of the master stream port.
// Depends on utf8sd_pkg and utf8_stream_decoder_unit_defines.svh.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_unit_defines.svh"

module utf8sd_out_reg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  utf8sd_pkg::res_t                    in_res,
    output logic                                in_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [utf8sd_pkg::TDATA_OUT_W-1:0]  m_tdata,   // [20:0] code_point
    output logic                                m_tlast,   // string_done
    output logic                                m_tuser    // [0] run_done
);

    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    utf8sd_pkg::res_t main_reg;
    utf8sd_pkg::res_t main_next;
    utf8sd_pkg::res_t skid_reg;
    utf8sd_pkg::res_t skid_next;

    // advance the main register when it drains, park in the skid stage on a stall
    always_comb begin
        m_tvalid_next   = m_tvalid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!m_tvalid_reg || m_tready) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                m_tvalid_next   = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next     = in_res;
                m_tvalid_next = in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_next       = in_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_tvalid_reg   <= m_tvalid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, main_reg.value};
    assign m_tlast  = main_reg.string_done;
    assign m_tuser  = main_reg.run_done;

    `UTF8SD_ASSERT_IMPL(a_skid_behind_main, skid_valid_reg, m_tvalid_reg)
    `UTF8SD_ASSERT_IMPL(a_skid_fill_on_stall, $rose(skid_valid_reg),
                        $past(m_tvalid_reg && !m_tready))

endmodule

// ----- rtl/utf8_stream_decoder_unit.sv -----
// UTF-8 stream decoder top level: byte buffer, front decoder and result register.
// Reset (aresetn low, synchronous) empties the byte buffer and clears the result
// and skid valid flags. Bytes are registered in the byte buffer and results in the
// result register (or the skid stage on a stall), which drives m_tdata. Throughput
// while the output is ready: one byte per cycle if each byte yields at most one
// result; a byte releasing several results holds the input, one result per cycle.
// Depends on utf8sd_pkg, utf8sd_decode, utf8sd_out_reg and the defines header.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_unit_defines.svh"

module utf8_stream_decoder_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [utf8sd_pkg::TDATA_IN_W-1:0]   s_tdata,   // [7:0] byte_in
    input  logic                                s_tlast,   // final_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [utf8sd_pkg::TDATA_OUT_W-1:0]  m_tdata,   // [20:0] code_point
    output logic                                m_tlast,   // string_done
    output logic                                m_tuser    // [0] run_done
);

    utf8sd_pkg::bytes4_t buf_reg;
    utf8sd_pkg::bytes4_t buf_next;
    logic [2:0]          cnt_reg;
    logic [2:0]          cnt_next;
    logic                fin_reg;
    logic                fin_next;

    utf8sd_pkg::dec_t    dec;
    utf8sd_pkg::bytes4_t dec_rem;
    utf8sd_pkg::bytes4_t keep_bytes;
    logic [2:0]          keep_count;
    utf8sd_pkg::res_t    res;
    logic                out_ready;
    logic                emit_fire;
    logic                s_fire;

    utf8sd_decode u_decode (
        .buf_bytes  (buf_reg),
        .buf_count  (cnt_reg),
        .final_flag (fin_reg),
        .dec        (dec),
        .rem_bytes  (dec_rem)
    );

    // hand the front result to the output stage
    always_comb begin
        emit_fire       = dec.work && out_ready;
        s_tready        = !dec.work || (emit_fire && dec.last);
        s_fire          = s_tvalid && s_tready;
        res.value       = dec.value;
        res.run_done    = dec.last;
        res.string_done = dec.last && fin_reg;
    end

    // drop consumed bytes, then append an accepted transaction behind what is held
    always_comb begin
        keep_bytes = emit_fire ? dec_rem : buf_reg;
        keep_count = emit_fire ? dec.rem_count : cnt_reg;
        buf_next   = keep_bytes;
        for (int k = 0; k < utf8sd_pkg::BUF_DEPTH; k++) begin
            if (s_fire && (keep_count == 3'(k))) begin
                buf_next[k] = s_tdata;
            end
        end
        cnt_next = keep_count + {2'd0, s_fire};
        fin_next = s_fire ? s_tlast : fin_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
            fin_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    utf8sd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (emit_fire),
        .in_res   (res),
        .in_ready (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `UTF8SD_ASSERT_IMPL(a_accept_on_last, s_fire && dec.work, emit_fire && dec.last)
    `UTF8SD_ASSERT_IMPL(a_held_not_final, !dec.work && (cnt_reg != 3'd0),
                        !fin_reg && (cnt_reg <= 3'd3))
    `UTF8SD_ASSERT_IMPL(a_string_done_ends_run, m_tvalid && m_tlast, m_tuser)

endmodule
